// ===== rtl/core/rlpd_pkg.sv =====
// Shared types and constants for the red line pixel detector.
`default_nettype none
package rlpd_pkg;

    localparam int C_CHAN_W      = 8;
    localparam int C_DEN_W       = C_CHAN_W + 1;
    localparam int C_PROD_W      = C_CHAN_W + C_DEN_W;
    localparam int C_SCALED_W    = C_PROD_W + 3;
    localparam int C_OUT_CNT_W   = 32;
    localparam logic [C_CHAN_W-1:0] C_FLOOR_RESET = 8'd100;

    localparam logic ACT_FIND  = 1'b0;
    localparam logic ACT_COUNT = 1'b1;

    typedef struct packed {
        logic [C_CHAN_W-1:0] blue;
        logic [C_CHAN_W-1:0] green;
        logic [C_CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic   action;
        t_pixel pix;
    } t_item;

endpackage
`default_nettype wire

// ===== rtl/core/rlpd_match.sv =====
// Redness compare logic: decides whether a pixel becomes best or is counted.
`default_nettype none
module rlpd_match (
    input  wire rlpd_pkg::t_item                     i_item,
    input  wire rlpd_pkg::t_pixel                    i_best,
    input  wire logic [rlpd_pkg::C_CHAN_W-1:0]       i_red_floor,
    output logic                                     o_hit
);
    import rlpd_pkg::*;

    logic [C_DEN_W-1:0]    own_den;
    logic [C_DEN_W-1:0]    top_den;
    logic [C_PROD_W-1:0]   prod_own;
    logic [C_PROD_W-1:0]   prod_top;
    logic [C_SCALED_W-1:0] scaled_own;
    logic [C_SCALED_W-1:0] scaled_top;
    logic [C_CHAN_W+2:0]   red5;
    logic [C_CHAN_W+2:0]   top_red4;
    logic                  find_hit;
    logic                  count_hit;

    // own_den = g + b + 1, top_den = best g + best b + 1
    assign own_den = C_DEN_W'(i_item.pix.green) + C_DEN_W'(i_item.pix.blue) + C_DEN_W'(1);
    assign top_den = C_DEN_W'(i_best.green) + C_DEN_W'(i_best.blue) + C_DEN_W'(1);

    assign prod_own = C_PROD_W'(i_item.pix.red) * C_PROD_W'(top_den);
    assign prod_top = C_PROD_W'(i_best.red) * C_PROD_W'(own_den);

    // 5*x as shift-add, 2*x as shift
    assign scaled_own = C_SCALED_W'({prod_own, 2'b00}) + C_SCALED_W'(prod_own);
    assign scaled_top = C_SCALED_W'({prod_top, 1'b0});

    assign red5     = (C_CHAN_W+3)'({i_item.pix.red, 2'b00}) + (C_CHAN_W+3)'(i_item.pix.red);
    assign top_red4 = (C_CHAN_W+3)'({i_best.red, 2'b00});

    assign find_hit  = (i_item.pix.red > i_red_floor) && (prod_own > prod_top);
    assign count_hit = (scaled_own > scaled_top) && (red5 > top_red4);

    always_comb begin
        case (i_item.action)
            ACT_FIND:  o_hit = find_hit;
            ACT_COUNT: o_hit = count_hit;
            default:   o_hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/red_line_pixel_detector_unit.sv =====
// Top level of the red line pixel detector: input register, compare, state and result register.
`default_nettype none
// One pixel per cycle while the output is not stalled. A pixel passes through
// the input register and then the compare-and-update stage that loads the best pixel,
// the hit counter and the result register at the same edge. A find transfer
// (action 0) replaces the best pixel when red exceeds red_floor and its redness
// 2r/(g+b+1) is strictly higher; a count transfer (action 1) bumps a saturating
// COUNT_WIDTH-bit counter when redness exceeds 0.4x and red exceeds 0.8x the
// best pixel's. Each transfer returns one result carrying the match flag, the
// low 32 bits of the counter and the best pixel after that transfer. red_floor resets
// to 100 and must be written only while the unit is idle; the unit does not enforce it.
module red_line_pixel_detector_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_cfg_we,
    input  wire logic [rlpd_pkg::C_CHAN_W-1:0]  i_cfg_data,

    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic [rlpd_pkg::C_CHAN_W-1:0]  i_blue,
    input  wire logic [rlpd_pkg::C_CHAN_W-1:0]  i_green,
    input  wire logic [rlpd_pkg::C_CHAN_W-1:0]  i_red,

    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_pixel_matched,
    output logic [rlpd_pkg::C_OUT_CNT_W-1:0]    o_line_pixel_count,
    output logic [rlpd_pkg::C_CHAN_W-1:0]       o_best_blue,
    output logic [rlpd_pkg::C_CHAN_W-1:0]       o_best_green,
    output logic [rlpd_pkg::C_CHAN_W-1:0]       o_best_red
);
    import rlpd_pkg::*;

    logic [C_CHAN_W-1:0]    r_red_floor;
    logic                   r_in_valid;
    t_item                  r_item;
    logic                   r_out_valid;
    logic                   r_hit;
    t_pixel                 r_best;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   adv_out;
    logic                   take_in;
    logic                   hit;
    t_item                  n_item;

    assign adv_out    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv_out;
    assign take_in    = i_in_valid && !o_in_stall;

    assign n_item.action    = i_action;
    assign n_item.pix.blue  = i_blue;
    assign n_item.pix.green = i_green;
    assign n_item.pix.red   = i_red;

    rlpd_match u_match (
        .i_item      (r_item),
        .i_best      (r_best),
        .i_red_floor (r_red_floor),
        .o_hit       (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_floor <= C_FLOOR_RESET;
        end else if (i_cfg_we) begin
            r_red_floor <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_item <= n_item;
        end
    end

    // state and result load together, so outputs read state directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_best      <= '0;
            r_count     <= '0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_hit <= hit;
                if (hit && r_item.action == ACT_FIND) begin
                    r_best <= r_item.pix;
                end
                if (hit && r_item.action == ACT_COUNT && r_count != '1) begin
                    r_count <= r_count + COUNT_WIDTH'(1);
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_matched = r_hit;
    assign o_best_blue     = r_best.blue;
    assign o_best_green    = r_best.green;
    assign o_best_red      = r_best.red;

    generate
        if (COUNT_WIDTH >= C_OUT_CNT_W) begin : g_cnt_trunc
            assign o_line_pixel_count = r_count[C_OUT_CNT_W-1:0];
        end else begin : g_cnt_ext
            assign o_line_pixel_count = {{(C_OUT_CNT_W-COUNT_WIDTH){1'b0}}, r_count};
        end
    endgenerate

endmodule
`default_nettype wire
